[rtl/cau_pkg.sv]
// Package for the complex arithmetic unit: item types, widths, mode codes.
// Also holds the saturation helpers used by the top level.
// No dependencies.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ProdW     = 2 * DataWidth;
  localparam int unsigned NumW      = ProdW + FracBits;
  localparam int unsigned QuotW     = DataWidth + 1;
  localparam int unsigned CmpW      = ProdW + QuotW;

  typedef enum logic [1:0] {
    ModeAdd = 2'd0,
    ModeSub = 2'd1,
    ModeMul = 2'd2,
    ModeDiv = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                       mode;
    logic signed [DataWidth-1:0] x_re;
    logic signed [DataWidth-1:0] x_im;
    logic signed [DataWidth-1:0] y_re;
    logic signed [DataWidth-1:0] y_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res_re;
    logic signed [DataWidth-1:0] res_im;
    logic                        overflow;
    logic                        div_zero;
  } cau_out_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] val;
    logic                        ovf;
  } sat_t;

  typedef struct packed {
    logic [NumW-1:0]  rem_re;
    logic [NumW-1:0]  rem_im;
    logic [QuotW-1:0] quo_re;
    logic [QuotW-1:0] quo_im;
    logic             big_re;
    logic             big_im;
    logic             neg_re;
    logic             neg_im;
    logic [ProdW-1:0] den;
    logic             is_div;
    logic             dz;
    cau_out_t         direct;
  } div_slot_t;

  localparam logic signed [ProdW:0] SatMax =
    {{(ProdW-DataWidth+2){1'b0}}, {(DataWidth-1){1'b1}}};
  localparam logic signed [ProdW:0] SatMin =
    {{(ProdW-DataWidth+2){1'b1}}, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] ValMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] ValMin = {1'b1, {(DataWidth-1){1'b0}}};

  function automatic sat_t sat_wide(input logic signed [ProdW:0] v);
    sat_t r;
    if (v > SatMax) begin
      r.val = ValMax;
      r.ovf = 1'b1;
    end else if (v < SatMin) begin
      r.val = ValMin;
      r.ovf = 1'b1;
    end else begin
      r.val = v[DataWidth-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t sat_quo(input logic neg, input logic big,
                                   input logic [QuotW-1:0] q);
    sat_t r;
    if (!neg) begin
      if (big || q[QuotW-1:DataWidth-1] != '0) begin
        r.val = ValMax;
        r.ovf = 1'b1;
      end else begin
        r.val = q[DataWidth-1:0];
        r.ovf = 1'b0;
      end
    end else begin
      if (big || q[QuotW-1] || (q[DataWidth-1] && q[DataWidth-2:0] != '0)) begin
        r.val = ValMin;
        r.ovf = 1'b1;
      end else begin
        r.val = -q[DataWidth-1:0];
        r.ovf = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

[rtl/cau_div.sv]
// Bit-per-stage restoring divider for both quotient lanes of the complex unit.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  cau_pkg::div_slot_t slot_i,
  output logic              vld_o,
  output cau_pkg::div_slot_t slot_o
);
  import cau_pkg::*;

  localparam int unsigned NumStages = QuotW + 1;

  typedef struct packed {
    logic            ge;
    logic [NumW-1:0] rem;
  } lane_t;

  function automatic lane_t lane_step(input logic [NumW-1:0] rem,
                                      input logic [ProdW-1:0] den,
                                      input int unsigned sh);
    logic [CmpW-1:0] rem_w;
    logic [CmpW-1:0] den_w;
    logic [CmpW-1:0] diff;
    lane_t r;
    rem_w = CmpW'(rem);
    den_w = CmpW'(den) << sh;
    diff  = rem_w - den_w;
    r.ge  = rem_w >= den_w;
    r.rem = r.ge ? diff[NumW-1:0] : rem;
    return r;
  endfunction

  div_slot_t               slot_q [NumStages];
  logic [NumStages-1:0]    vld_q;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    localparam int unsigned Shift = QuotW - s;
    div_slot_t prev;
    div_slot_t slot_d;
    logic      prev_v;
    lane_t     lre;
    lane_t     lim;

    if (s == 0) begin : g_first
      assign prev   = slot_i;
      assign prev_v = vld_i;
    end else begin : g_next
      assign prev   = slot_q[s-1];
      assign prev_v = vld_q[s-1];
    end

    assign lre = lane_step(prev.rem_re, prev.den, Shift);
    assign lim = lane_step(prev.rem_im, prev.den, Shift);

    if (s == 0) begin : g_big
      always_comb begin
        slot_d        = prev;
        slot_d.big_re = lre.ge;
        slot_d.big_im = lim.ge;
      end
    end else begin : g_bit
      always_comb begin
        slot_d               = prev;
        slot_d.rem_re        = lre.rem;
        slot_d.rem_im        = lim.rem;
        slot_d.quo_re[Shift] = lre.ge;
        slot_d.quo_im[Shift] = lim.ge;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      slot_q[s] <= slot_d;
    end
  end

  assign vld_o  = vld_q[NumStages-1];
  assign slot_o = slot_q[NumStages-1];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> $past(vld_i, NumStages))
    else $error("divider valid chain invented an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |-> ##NumStages vld_o)
    else $error("divider valid chain lost an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_o && slot_o.dz) |-> slot_o.is_div)
    else $error("zero divisor flagged outside divide mode");

endmodule

[rtl/complex_arith_unit_top.sv]
// Top level of the complex arithmetic unit: add, subtract, multiply, divide
// on signed fixed-point complex pairs. Depends on cau_pkg and cau_div.
//
//   port          dir  role
//   start_i       in   item strobe, taken when busy_o is low
//   busy_o        out  always low, an item enters every cycle
//   op_i          in   operation and operands
//   res_valid_o   out  result strobe, one cycle per item
//   res_o         out  result parts and flags
//
// Every item takes 38 register stages: input, products, sums, DataWidth+2
// divider steps (overflow check, then one quotient bit each, both lanes),
// output register. The result strobe rises in accept order.
// Reset clears only the valid bits. The receiver cannot stall; no item waits.
`timescale 1ns / 1ps
module complex_arith_unit_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  cau_pkg::cau_in_t op_i,
  output logic             res_valid_o,
  output cau_pkg::cau_out_t res_o
);
  import cau_pkg::*;

  cau_in_t in_q;
  logic    in_vld_q;

  logic signed [ProdW-1:0] p_ac_q, p_bd_q, p_ad_q, p_bc_q, p_cc_q, p_dd_q;
  mode_e                   mode2_q;
  cau_out_t                as_q;
  logic                    vld2_q;

  div_slot_t slot_d, slot_q;
  logic      vld3_q;

  logic      dv_vld;
  div_slot_t dv_slot;

  cau_out_t  res_d, res_q;
  logic      res_vld_q;

  logic signed [DataWidth:0] sum_re, sum_im;
  sat_t                      sre, sim;
  cau_out_t                  as_d;

  logic signed [ProdW:0] t_mre, t_mim, n_re, n_im;
  logic [ProdW-1:0]      mag_re, mag_im, den;
  sat_t                  mre, mim, qre, qim;

  assign busy_o = 1'b0;

  always_comb begin
    if (in_q.mode == ModeSub) begin
      sum_re = {in_q.x_re[DataWidth-1], in_q.x_re} - {in_q.y_re[DataWidth-1], in_q.y_re};
      sum_im = {in_q.x_im[DataWidth-1], in_q.x_im} - {in_q.y_im[DataWidth-1], in_q.y_im};
    end else begin
      sum_re = {in_q.x_re[DataWidth-1], in_q.x_re} + {in_q.y_re[DataWidth-1], in_q.y_re};
      sum_im = {in_q.x_im[DataWidth-1], in_q.x_im} + {in_q.y_im[DataWidth-1], in_q.y_im};
    end
    sre            = sat_wide((ProdW+1)'(sum_re));
    sim            = sat_wide((ProdW+1)'(sum_im));
    as_d.res_re    = sre.val;
    as_d.res_im    = sim.val;
    as_d.overflow  = sre.ovf | sim.ovf;
    as_d.div_zero  = 1'b0;
  end

  always_comb begin
    t_mre  = {p_ac_q[ProdW-1], p_ac_q} - {p_bd_q[ProdW-1], p_bd_q};
    t_mim  = {p_ad_q[ProdW-1], p_ad_q} + {p_bc_q[ProdW-1], p_bc_q};
    n_re   = {p_ac_q[ProdW-1], p_ac_q} + {p_bd_q[ProdW-1], p_bd_q};
    n_im   = {p_bc_q[ProdW-1], p_bc_q} - {p_ad_q[ProdW-1], p_ad_q};
    den    = p_cc_q + p_dd_q;
    mag_re = n_re[ProdW] ? ProdW'(-n_re) : ProdW'(n_re);
    mag_im = n_im[ProdW] ? ProdW'(-n_im) : ProdW'(n_im);
    mre    = sat_wide(t_mre >>> FracBits);
    mim    = sat_wide(t_mim >>> FracBits);

    slot_d.rem_re = NumW'(mag_re) << FracBits;
    slot_d.rem_im = NumW'(mag_im) << FracBits;
    slot_d.quo_re = '0;
    slot_d.quo_im = '0;
    slot_d.big_re = 1'b0;
    slot_d.big_im = 1'b0;
    slot_d.neg_re = n_re[ProdW];
    slot_d.neg_im = n_im[ProdW];
    slot_d.den    = den;
    slot_d.is_div = (mode2_q == ModeDiv);
    slot_d.dz     = (mode2_q == ModeDiv) && (den == '0);
    if (mode2_q == ModeMul) begin
      slot_d.direct.res_re   = mre.val;
      slot_d.direct.res_im   = mim.val;
      slot_d.direct.overflow = mre.ovf | mim.ovf;
      slot_d.direct.div_zero = 1'b0;
    end else begin
      slot_d.direct = as_q;
    end
  end

  cau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld3_q),
    .slot_i (slot_q),
    .vld_o  (dv_vld),
    .slot_o (dv_slot)
  );

  always_comb begin
    qre = sat_quo(dv_slot.neg_re, dv_slot.big_re, dv_slot.quo_re);
    qim = sat_quo(dv_slot.neg_im, dv_slot.big_im, dv_slot.quo_im);
    if (!dv_slot.is_div) begin
      res_d = dv_slot.direct;
    end else if (dv_slot.dz) begin
      res_d.res_re   = '0;
      res_d.res_im   = '0;
      res_d.overflow = 1'b0;
      res_d.div_zero = 1'b1;
    end else begin
      res_d.res_re   = qre.val;
      res_d.res_im   = qim.val;
      res_d.overflow = qre.ovf | qim.ovf;
      res_d.div_zero = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      vld2_q    <= in_vld_q;
      vld3_q    <= vld2_q;
      res_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= op_i;
    p_ac_q  <= in_q.x_re * in_q.y_re;
    p_bd_q  <= in_q.x_im * in_q.y_im;
    p_ad_q  <= in_q.x_re * in_q.y_im;
    p_bc_q  <= in_q.x_im * in_q.y_re;
    p_cc_q  <= in_q.y_re * in_q.y_re;
    p_dd_q  <= in_q.y_im * in_q.y_im;
    mode2_q <= in_q.mode;
    as_q    <= as_d;
    slot_q  <= slot_d;
    res_q   <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.div_zero) |->
      (res_o.res_re == '0 && res_o.res_im == '0 && !res_o.overflow))
    else $error("zero divisor result not cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o == $past(dv_vld))
    else $error("output strobe out of step with divider");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld3_q && slot_q.dz) |-> (slot_q.den == '0))
    else $error("zero divisor flag with nonzero divisor");

endmodule
